// ===== rtl/core/session_sequence_tracker_core_macros.svh =====
// Assertion macros for the session sequence tracker checker.
`ifndef SESSION_SEQUENCE_TRACKER_CORE_MACROS_SVH
`define SESSION_SEQUENCE_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("session tracker check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("session tracker check failed");

`endif

// ===== rtl/core/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Types, codes and sizes shared by the session sequence tracker modules.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int SESSIONS = 16;
	localparam int SLOT_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int QDEPTH   = 2;

	typedef enum logic [1:0] {
		CMD_HELLO   = 2'd0,
		CMD_DATA    = 2'd1,
		CMD_ALIVE   = 2'd2,
		CMD_GOODBYE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RK_NONE    = 2'd0,
		RK_HELLO   = 2'd1,
		RK_ALIVE   = 2'd2,
		RK_GOODBYE = 2'd3
	} reply_t;

	typedef enum logic [2:0] {
		EV_CREATED   = 3'd0,
		EV_ACCEPTED  = 3'd1,
		EV_DUPLICATE = 3'd2,
		EV_PROTOCOL  = 3'd3,
		EV_CLOSED    = 3'd4,
		EV_UNKNOWN   = 3'd5,
		EV_BADOPEN   = 3'd6,
		EV_FULL      = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOOK,
		BK_EXEC,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [31:0] session_id;
		logic [1:0]  command;
		logic [31:0] seq_number;
	} hdr_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [31:0] reply_session;
		logic [31:0] reply_seq;
		logic [2:0]  event_res;
		logic [31:0] lost_count;
		logic [3:0]  slot_index;
	} res_t;

	// A header together with the flags the front end derives from it.
	typedef struct packed {
		hdr_t hdr;
		logic hello_open;
		logic is_data;
		logic is_goodbye;
	} qent_t;

endpackage

// ===== rtl/core/sst_queue.sv =====
// ----------------------------------------------------------------------------
// sst_queue
// Short FIFO of classified headers between the front end and the back end.
// ----------------------------------------------------------------------------
module sst_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sst_pkg::qent_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output sst_pkg::qent_t pop_data
);
	import sst_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	qent_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/sst_front.sv =====
// ----------------------------------------------------------------------------
// sst_front
// Accepts headers, classifies the command and feeds the queue.
// ----------------------------------------------------------------------------
module sst_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hdr_valid,
	output logic           hdr_stall,
	input  sst_pkg::hdr_t  hdr,
	output logic           push,
	output sst_pkg::qent_t push_data,
	input  logic           q_full
);
	import sst_pkg::*;

	logic  valid_s1;
	qent_t entry_s1;
	logic  take;

	// The input register empties into the queue in the same cycle it refills.
	assign hdr_stall = valid_s1 && q_full;
	assign take      = hdr_valid && !hdr_stall;
	assign push      = valid_s1 && !q_full;
	assign push_data = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.hdr        <= hdr;
			entry_s1.hello_open <= (hdr.command == CMD_HELLO) && (hdr.seq_number == '0);
			entry_s1.is_data    <= (hdr.command == CMD_DATA);
			entry_s1.is_goodbye <= (hdr.command == CMD_GOODBYE);
		end
	end

endmodule

// ===== rtl/core/sst_back.sv =====
// ----------------------------------------------------------------------------
// sst_back
// Session table lookup, protocol rules, table update and result register.
// ----------------------------------------------------------------------------
module sst_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nonempty,
	input  sst_pkg::qent_t q_data,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_stall,
	output sst_pkg::res_t  res
);
	import sst_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic              look_en;
	logic              exec_en;

	logic              valid_q [SESSIONS];
	logic [31:0]       sess_q  [SESSIONS];
	logic [31:0]       exp_q   [SESSIONS];

	qent_t             item_s1;
	logic              found_s2;
	logic              full_s2;
	logic [SLOT_W-1:0] slot_s2;
	res_t              res_q;

	logic              found_c;
	logic              have_free_c;
	logic [SLOT_W-1:0] match_slot_c;
	logic [SLOT_W-1:0] free_slot_c;

	logic [31:0]       expv;
	logic [31:0]       seq;
	logic [31:0]       new_exp;
	logic              keep;
	res_t              res_d;

	// Control: pop, lookup, execute, then hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		look_en = 1'b0;
		exec_en = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_nonempty) begin
					q_pop   = 1'b1;
					state_d = BK_LOOK;
				end
			end
			BK_LOOK: begin
				look_en = 1'b1;
				state_d = BK_EXEC;
			end
			BK_EXEC: begin
				exec_en = 1'b1;
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!res_stall) begin
					if (q_nonempty) begin
						q_pop   = 1'b1;
						state_d = BK_LOOK;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign res_valid = (state_q == BK_OUT);
	assign res       = res_q;

	// Parallel compare across all slots; the lowest match and lowest free slot win.
	always_comb begin
		found_c      = 1'b0;
		have_free_c  = 1'b0;
		match_slot_c = '0;
		free_slot_c  = '0;
		for (int k = SESSIONS - 1; k >= 0; k--) begin
			if (valid_q[k]) begin
				if (sess_q[k] == item_s1.hdr.session_id) begin
					found_c      = 1'b1;
					match_slot_c = SLOT_W'(k);
				end
			end else begin
				have_free_c = 1'b1;
				free_slot_c = SLOT_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_data;
		end
		if (look_en) begin
			found_s2 <= found_c;
			full_s2  <= !found_c && !have_free_c;
			slot_s2  <= found_c ? match_slot_c : free_slot_c;
		end
	end

	// Protocol rules for the selected slot. A newly allocated slot expects zero.
	assign expv = found_s2 ? exp_q[slot_s2] : '0;
	assign seq  = item_s1.hdr.seq_number;

	always_comb begin
		new_exp             = expv;
		keep                = 1'b1;
		res_d.reply_kind    = RK_NONE;
		res_d.reply_session = item_s1.hdr.session_id;
		res_d.reply_seq     = '0;
		res_d.event_res     = EV_FULL;
		res_d.lost_count    = '0;
		res_d.slot_index    = 4'(slot_s2);
		if (full_s2) begin
			res_d.reply_session = '0;
			res_d.slot_index    = '0;
		end else if (expv == '0) begin
			if (item_s1.hello_open) begin
				new_exp          = 32'd1;
				res_d.reply_kind = RK_HELLO;
				res_d.event_res  = EV_CREATED;
			end else begin
				keep             = 1'b0;
				res_d.reply_kind = RK_GOODBYE;
				res_d.event_res  = EV_BADOPEN;
			end
		end else if (item_s1.is_data) begin
			if (seq < expv) begin
				res_d.reply_seq = expv;
				if (seq + 32'd1 == expv) begin
					res_d.reply_kind = RK_ALIVE;
					res_d.event_res  = EV_DUPLICATE;
				end else begin
					keep             = 1'b0;
					res_d.reply_kind = RK_GOODBYE;
					res_d.event_res  = EV_PROTOCOL;
				end
			end else begin
				new_exp          = seq + 32'd1;
				res_d.reply_kind = RK_ALIVE;
				res_d.reply_seq  = seq;
				res_d.event_res  = EV_ACCEPTED;
				res_d.lost_count = seq - expv;
			end
		end else begin
			keep             = 1'b0;
			res_d.reply_kind = RK_GOODBYE;
			res_d.reply_seq  = expv;
			res_d.event_res  = item_s1.is_goodbye ? EV_CLOSED : EV_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SESSIONS; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else if (exec_en && !full_s2) begin
			valid_q[slot_s2] <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			res_q <= res_d;
			if (!full_s2) begin
				exp_q[slot_s2] <= new_exp;
				if (!found_s2) begin
					sess_q[slot_s2] <= item_s1.hdr.session_id;
				end
			end
		end
	end

endmodule

// ===== rtl/core/session_sequence_tracker_core.sv =====
// ----------------------------------------------------------------------------
// session_sequence_tracker_core
// Tracks sequence numbers of packet sessions and produces one reply per header.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// hdr       in         hdr_valid/hdr_stall  hdr_t: session_id, command, seq_number
// res       out        res_valid/res_stall  res_t: reply, event, lost count, slot
//
// The back end takes one header at a time through pop, table lookup, execute and
// update; it pops the next header only when the result is taken.
// A header passes the front register, the queue, the back end and the result register.
// Reset clears the session valid bits at once; there is no clearing pass.
// A stalled result holds the back end; the front register and queue keep
// taking headers until the queue is full and the front register holds one.
// ----------------------------------------------------------------------------
module session_sequence_tracker_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hdr_valid,
	output logic          hdr_stall,
	input  sst_pkg::hdr_t hdr,
	output logic          res_valid,
	input  logic          res_stall,
	output sst_pkg::res_t res
);
	import sst_pkg::*;

	logic  push;
	qent_t push_data;
	logic  q_full;
	logic  q_pop;
	logic  q_nonempty;
	qent_t q_data;

	sst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_stall (hdr_stall),
		.hdr       (hdr),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	sst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (q_data)
	);

	sst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule

// ===== rtl/core/sst_checker.sv =====
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the session sequence tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "session_sequence_tracker_core_macros.svh"

module sst_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          hdr_valid,
	input logic          hdr_stall,
	input sst_pkg::hdr_t hdr,
	input logic          res_valid,
	input logic          res_stall,
	input sst_pkg::res_t res
);
	import sst_pkg::*;

	// A result waiting on the receiver stays put.
	`SST_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

	// A full table yields an empty result.
	`SST_ASSERT_NOW(a_full_empty, res_valid && (res.event_res == EV_FULL), (res.reply_kind == RK_NONE) && (res.reply_session == '0) && (res.slot_index == '0))

	// Only accepted data reports lost packets.
	`SST_ASSERT_NOW(a_lost_only_data, res_valid && (res.event_res != EV_ACCEPTED), res.lost_count == '0)

	// Every closing event answers with GOODBYE.
	`SST_ASSERT_NOW(a_close_goodbye, res_valid && ((res.event_res == EV_PROTOCOL) || (res.event_res == EV_CLOSED) || (res.event_res == EV_UNKNOWN) || (res.event_res == EV_BADOPEN)), res.reply_kind == RK_GOODBYE)

endmodule

bind session_sequence_tracker_core sst_checker u_sst_checker (.*);
